// ===== rtl/mlr_pkg.sv =====
// shared types and constants of the multichannel linear ramp
`default_nettype none

package mlr_pkg;

    localparam int unsigned CH_W        = 5;
    localparam int unsigned LEVEL_W     = 15;
    localparam int unsigned TICK_W      = 16;
    localparam int unsigned PROD_W      = LEVEL_W + TICK_W;
    localparam int unsigned QUOT_W      = LEVEL_W;
    localparam int unsigned DIV_STEPS   = QUOT_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int unsigned MAX_LIVE_CH = 32;
    localparam int unsigned NUM_CHANNELS_DEF = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(25600);

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/mlr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module mlr_div
    import mlr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [PROD_W-1:0]   i_dividend,
    input  wire logic [TICK_W-1:0]   i_divisor,
    output logic                     o_done,
    output logic [QUOT_W-1:0]        o_quot
);

    logic [TICK_W-1:0]    r_rem;
    logic [QUOT_W-1:0]    r_quo;
    logic [TICK_W-1:0]    r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [TICK_W:0] w_trial;
    logic [TICK_W:0] w_diff;
    logic            w_ge;

    assign w_trial = {r_rem, r_quo[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // quotient fits in QUOT_W bits, so the upper dividend part is already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:QUOT_W];
            r_quo <= i_dividend[QUOT_W-1:0];
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[TICK_W-1:0] : w_trial[TICK_W-1:0];
            r_quo <= {r_quo[QUOT_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ===== rtl/multichannel_linear_ramp.sv =====
// top level: per-channel ramp state, tick sequencer and result register
//
// input channel: i_valid / o_stall carry one command per transfer. a start
// command loads a ramp on one channel and gives no result.
// a tick command walks the live channels in order and gives one result per
// channel on the output channel (o_valid / i_stall), o_last on the final one.
// a channel that is idle or finishing its ramp passes through S_CALC and
// S_OUT; a channel still ramping runs one multiply in S_CALC, then the
// shared bit-serial divider in S_DIV, the level update in S_FIN and S_OUT.
// o_stall is high from the accepted tick until its last result transfers.
// a stalled result holds in the output register and the walk waits on it.
// reset idles every channel and clears every level to zero.
`default_nettype none

module multichannel_linear_ramp
    import mlr_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_command,
    input  wire logic [CH_W-1:0]    i_channel,
    input  wire logic [LEVEL_W-1:0] i_target_level,
    input  wire logic [TICK_W-1:0]  i_ramp_ticks,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [CH_W-1:0]         o_channel_out,
    output logic [LEVEL_W-1:0]      o_level,
    output logic                    o_ramping,
    output logic                    o_last
);

    localparam int unsigned LIVE_CH = (NUM_CHANNELS < MAX_LIVE_CH) ? NUM_CHANNELS : MAX_LIVE_CH;
    localparam int unsigned IDX_W   = (LIVE_CH > 1) ? $clog2(LIVE_CH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIVE_CH - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [LEVEL_W-1:0] r_cur_level   [0:LIVE_CH-1];
    logic [LEVEL_W-1:0] r_start_level [0:LIVE_CH-1];
    logic [LEVEL_W-1:0] r_target      [0:LIVE_CH-1];
    logic [LEVEL_W-1:0] r_delta_mag   [0:LIVE_CH-1];
    logic               r_delta_neg   [0:LIVE_CH-1];
    logic [TICK_W-1:0]  r_elapsed     [0:LIVE_CH-1];
    logic [TICK_W-1:0]  r_duration    [0:LIVE_CH-1];
    logic               r_active      [0:LIVE_CH-1];

    logic [IDX_W-1:0]   r_ch, n_ch;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;
    logic               r_out_ramping, n_out_ramping;

    logic               w_in_xfer;
    logic               w_start_ok;
    logic [IDX_W-1:0]   w_idx;
    logic [IDX_W-1:0]   w_wr_idx;
    logic [LEVEL_W-1:0] w_tgt_sat;
    logic [LEVEL_W-1:0] w_cur_rd;
    logic [TICK_W:0]    w_cnt;
    logic               w_finish;
    logic [PROD_W-1:0]  w_prod;
    logic [LEVEL_W-1:0] w_new_level;
    logic               w_div_start;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_start_ok = w_in_xfer && (t_cmd'(i_command) == CMD_START)
                        && ({1'b0, i_channel} < (CH_W + 1)'(LIVE_CH));
    assign w_wr_idx   = i_channel[IDX_W-1:0];
    assign w_idx      = (r_state == S_IDLE) ? w_wr_idx : r_ch;
    assign w_cur_rd   = r_cur_level[w_idx];
    assign w_tgt_sat  = (i_target_level > LEVEL_MAX) ? LEVEL_MAX : i_target_level;

    assign w_cnt    = {1'b0, r_elapsed[r_ch]} + (TICK_W + 1)'(1);
    assign w_finish = (w_cnt >= {1'b0, r_duration[r_ch]});
    assign w_prod   = PROD_W'(r_delta_mag[r_ch]) * PROD_W'(w_cnt[TICK_W-1:0]);

    assign w_div_start = (r_state == S_CALC) && r_active[r_ch] && !w_finish;

    assign w_new_level = r_delta_neg[r_ch] ? (r_start_level[r_ch] - w_quot)
                                           : (r_start_level[r_ch] + w_quot);

    mlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_duration[r_ch]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state       = r_state;
        n_ch          = r_ch;
        n_out_level   = r_out_level;
        n_out_ramping = r_out_ramping;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (t_cmd'(i_command) == CMD_TICK)) begin
                    n_ch    = '0;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (!r_active[r_ch]) begin
                    n_out_level   = w_cur_rd;
                    n_out_ramping = 1'b0;
                    n_state       = S_OUT;
                end else if (w_finish) begin
                    n_out_level   = r_target[r_ch];
                    n_out_ramping = 1'b0;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_out_level   = w_new_level;
                n_out_ramping = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_ch == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ch    = r_ch + IDX_W'(1);
                        n_state = S_CALC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            for (int i = 0; i < LIVE_CH; i++) begin
                r_active[i]    <= 1'b0;
                r_cur_level[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            if (w_start_ok) begin
                r_active[w_wr_idx] <= 1'b1;
            end else if ((r_state == S_CALC) && r_active[r_ch] && w_finish) begin
                r_active[r_ch]    <= 1'b0;
                r_cur_level[r_ch] <= r_target[r_ch];
            end else if (r_state == S_FIN) begin
                r_cur_level[r_ch] <= w_new_level;
            end
        end
    end

    // ramp parameters and result register; the parameters are only read while the channel is active
    always_ff @(posedge i_clk) begin
        r_out_level   <= n_out_level;
        r_out_ramping <= n_out_ramping;
        if (w_start_ok) begin
            r_target[w_wr_idx]      <= w_tgt_sat;
            r_start_level[w_wr_idx] <= w_cur_rd;
            r_delta_neg[w_wr_idx]   <= (w_tgt_sat < w_cur_rd);
            r_delta_mag[w_wr_idx]   <= (w_tgt_sat < w_cur_rd) ? (w_cur_rd - w_tgt_sat)
                                                              : (w_tgt_sat - w_cur_rd);
            r_elapsed[w_wr_idx]     <= '0;
            r_duration[w_wr_idx]    <= i_ramp_ticks;
        end else if ((r_state == S_CALC) && r_active[r_ch]) begin
            if (w_finish) begin
                r_elapsed[r_ch]  <= '0;
                r_duration[r_ch] <= '0;
            end else begin
                r_elapsed[r_ch] <= w_cnt[TICK_W-1:0];
            end
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_channel_out = CH_W'(r_ch);
    assign o_level       = r_out_level;
    assign o_ramping     = r_out_ramping;
    assign o_last        = (r_ch == LAST_IDX);

endmodule

`default_nettype wire
